### src/tbw_pkg.sv
// Shared constants and types for the token bucket / window budget limiter.
// Used by the channel interfaces, the top level, the checker and the testbench.
// No dependencies.
package tbw_pkg;

   // Field widths
   localparam int OP_W        = 2;
   localparam int AMOUNT_W    = 32;
   localparam int STATUS_W    = 2;
   localparam int USAGE_W     = 48;
   localparam int TOKEN_W     = 16;
   localparam int RATE_W      = 32;
   localparam int WINDOW_W    = 32;
   localparam int TICK_W      = 32;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 2;

   // Parameter defaults
   localparam int WINDOW_DEPTH_DEF        = 64;
   localparam int TOKEN_FRACTION_BITS_DEF = 16;

   // Register reset values
   localparam logic [RATE_W-1:0]   RATE_RESET   = 32'd3932160;
   localparam logic [TOKEN_W-1:0]  BURST_RESET  = 16'd60;
   localparam logic [USAGE_W-1:0]  BUDGET_RESET = 48'd0;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd86400;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_ACQUIRE = 2'd1,
      OP_RECORD  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_DENY_BUDGET = 2'd1,
      ST_DENY_RATE   = 2'd2,
      ST_WIN_FULL    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATE   = 2'd0,
      CSR_BURST  = 2'd1,
      CSR_BUDGET = 2'd2,
      CSR_WINDOW = 2'd3
   } csr_index_type;

endpackage

### src/tbw_if.sv
// Request and response channel interfaces (valid/ready) for the limiter.
// Depends on tbw_pkg for field widths.
interface tbw_req_if;
   logic                         valid;
   logic                         ready;
   logic [tbw_pkg::OP_W-1:0]     op;
   logic [tbw_pkg::AMOUNT_W-1:0] usage_amount;

   modport source (output valid, output op, output usage_amount, input ready);
   modport sink   (input valid, input op, input usage_amount, output ready);
endinterface

interface tbw_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tbw_pkg::STATUS_W-1:0] status;
   logic [tbw_pkg::USAGE_W-1:0]  usage_total;
   logic [tbw_pkg::TOKEN_W-1:0]  tokens_available;
   logic                         budget_exceeded;

   modport source (output valid, output status, output usage_total,
                   output tokens_available, output budget_exceeded, input ready);
   modport sink   (input valid, input status, input usage_total,
                   input tokens_available, input budget_exceeded, output ready);
endinterface

### src/tbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tbw_alu.sv
// Shared add/subtract unit; carry is the carry out on add, the borrow on sub.
// No dependencies.
module tbw_alu #(
   parameter int W = 48
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         sub,
   output logic [W-1:0] result,
   output logic         carry
);

   logic [W:0] wide;

   // Extra top bit gives carry out on add and borrow on subtract
   always_comb begin
      if (sub) begin
         wide = {1'b0, a} - {1'b0, b};
      end else begin
         wide = {1'b0, a} + {1'b0, b};
      end
   end

   assign result = wide[W-1:0];
   assign carry  = wide[W];

endmodule

### src/token_bucket_with_window_budget.sv
// Token bucket with sliding-window usage budget. One request at a time.
// States per op, from accept: op 3 FLAG; record REC, FLAG; acquire ACQ_BUD,
// ACQ_TOK unless budget-denied, FLAG; tick ADD, CAP, READ, AGE, WIN, SUB, READ
// per expired entry, AGE, WIN at a live one, FLAG; then RESP, IDLE. The
// sequencer drives one shared adder; the ring is read one entry per step.
// Reset (synchronous, active high): bucket full, ring empty, sum and tick zero.
module token_bucket_with_window_budget #(
   parameter int WINDOW_DEPTH        = tbw_pkg::WINDOW_DEPTH_DEF,
   parameter int TOKEN_FRACTION_BITS = tbw_pkg::TOKEN_FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tbw_req_if.sink                         req,
   tbw_rsp_if.source                       rsp,
   input  logic                            csr_wr_en,
   input  logic [tbw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tbw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int F       = TOKEN_FRACTION_BITS;
   localparam int LVL_W   = tbw_pkg::TOKEN_W + F;
   localparam int PTR_W   = $clog2(WINDOW_DEPTH);
   localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
   // Usage width covers the level plus rate with room for the carry
   localparam int ALU_W   = tbw_pkg::USAGE_W;
   localparam int ENTRY_W = tbw_pkg::TICK_W + tbw_pkg::AMOUNT_W;

   localparam logic [PTR_W:0]   DEPTH_P  = (PTR_W + 1)'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] LAST_P   = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_C   = CNT_W'(WINDOW_DEPTH);
   localparam logic [LVL_W-1:0] ONE_TOK  = LVL_W'(1) << F;
   localparam logic [LVL_W-1:0] LVL_RST  = LVL_W'(tbw_pkg::BURST_RESET) << F;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_ADD     = 12'b0000_0000_0010,
      S_CAP     = 12'b0000_0000_0100,
      S_READ    = 12'b0000_0000_1000,
      S_AGE     = 12'b0000_0001_0000,
      S_WIN     = 12'b0000_0010_0000,
      S_SUB     = 12'b0000_0100_0000,
      S_ACQ_BUD = 12'b0000_1000_0000,
      S_ACQ_TOK = 12'b0001_0000_0000,
      S_REC     = 12'b0010_0000_0000,
      S_FLAG    = 12'b0100_0000_0000,
      S_RESP    = 12'b1000_0000_0000
   } state_type;

   // Configuration registers
   logic [tbw_pkg::RATE_W-1:0]   rate_ff;
   logic [tbw_pkg::TOKEN_W-1:0]  burst_ff;
   logic [tbw_pkg::USAGE_W-1:0]  budget_ff;
   logic [tbw_pkg::WINDOW_W-1:0] window_ff;

   // Limiter state
   state_type                    state_ff, state_in;
   logic [LVL_W-1:0]             level_ff, level_in;
   logic [tbw_pkg::TICK_W-1:0]   tick_ff, tick_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [tbw_pkg::USAGE_W-1:0]  sum_ff, sum_in;
   logic [ALU_W-1:0]             work_ff, work_in;
   logic [tbw_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   tbw_pkg::status_type          status_ff, status_in;
   logic                         flag_ff, flag_in;

   // Shared adder hookup
   logic [ALU_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_sub, alu_carry;

   // Ring access
   logic                         ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]             slot;
   logic [PTR_W:0]               slot_sum;
   logic [ENTRY_W-1:0]           ram_wr_data, ram_rd_data;
   logic [tbw_pkg::TICK_W-1:0]   rd_stamp;
   logic [tbw_pkg::AMOUNT_W-1:0] rd_amount;

   // Effective settings
   logic [tbw_pkg::TOKEN_W-1:0]  burst_eff;
   logic [LVL_W-1:0]             cap;
   logic [tbw_pkg::RATE_W-1:0]   rate_eff;
   logic                         ring_full, accept;

   assign burst_eff = (burst_ff == '0) ? tbw_pkg::TOKEN_W'(1) : burst_ff;
   assign cap       = LVL_W'(burst_eff) << F;
   assign rate_eff  = (rate_ff == '0) ? tbw_pkg::RATE_W'(ONE_TOK) : rate_ff;
   assign ring_full = (count_ff == FULL_C);
   assign accept    = req.valid && req.ready;

   assign rd_stamp  = ram_rd_data[ENTRY_W-1:tbw_pkg::AMOUNT_W];
   assign rd_amount = ram_rd_data[tbw_pkg::AMOUNT_W-1:0];

   // Tail slot: head plus count, wrapped once
   assign slot_sum = {1'b0, head_ff} + {1'b0, count_ff[PTR_W-1:0]};
   assign slot = (slot_sum >= DEPTH_P) ? PTR_W'(slot_sum - DEPTH_P) : slot_sum[PTR_W-1:0];

   assign ram_wr_en   = (state_ff == S_REC) && !ring_full;
   assign ram_wr_data = {tick_ff, amount_ff};
   assign ram_rd_en   = (state_ff == S_READ) && (count_ff != '0);

   tbw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   tbw_alu #(
      .W (ALU_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .carry  (alu_carry)
   );

   // Operand select for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_ADD: begin
            alu_a = ALU_W'(level_ff);
            alu_b = ALU_W'(rate_eff);
         end
         S_CAP: begin
            alu_a   = ALU_W'(cap);
            alu_b   = work_ff;
            alu_sub = 1'b1;
         end
         S_AGE: begin
            alu_a   = ALU_W'(tick_ff);
            alu_b   = ALU_W'(rd_stamp);
            alu_sub = 1'b1;
         end
         S_WIN: begin
            alu_a   = ALU_W'(window_ff);
            alu_b   = work_ff;
            alu_sub = 1'b1;
         end
         S_SUB: begin
            alu_a   = ALU_W'(sum_ff);
            alu_b   = ALU_W'(rd_amount);
            alu_sub = 1'b1;
         end
         S_ACQ_BUD, S_FLAG: begin
            alu_a   = ALU_W'(sum_ff);
            alu_b   = ALU_W'(budget_ff);
            alu_sub = 1'b1;
         end
         S_ACQ_TOK: begin
            alu_a   = ALU_W'(level_ff);
            alu_b   = ALU_W'(ONE_TOK);
            alu_sub = 1'b1;
         end
         S_REC: begin
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(amount_ff);
         end
         S_IDLE, S_READ, S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      tick_in   = tick_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      work_in   = work_ff;
      amount_in = amount_ff;
      status_in = status_ff;
      flag_in   = flag_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               amount_in = req.usage_amount;
               status_in = tbw_pkg::ST_OK;
               unique case (tbw_pkg::op_type'(req.op))
                  tbw_pkg::OP_TICK:    state_in = S_ADD;
                  tbw_pkg::OP_ACQUIRE: state_in = S_ACQ_BUD;
                  tbw_pkg::OP_RECORD:  state_in = S_REC;
                  default:             state_in = S_FLAG;
               endcase
            end
         end
         S_ADD: begin
            work_in  = alu_res;
            tick_in  = tick_ff + tbw_pkg::TICK_W'(1);
            state_in = S_CAP;
         end
         S_CAP: begin
            // Borrow means the new level passed the cap
            level_in = alu_carry ? cap : work_ff[LVL_W-1:0];
            state_in = S_READ;
         end
         S_READ: begin
            state_in = (count_ff == '0) ? S_FLAG : S_AGE;
         end
         S_AGE: begin
            work_in  = ALU_W'(alu_res[tbw_pkg::TICK_W-1:0]);
            state_in = S_WIN;
         end
         S_WIN: begin
            // Borrow means age is past the window: expire the entry
            state_in = alu_carry ? S_SUB : S_FLAG;
         end
         S_SUB: begin
            sum_in   = alu_carry ? '0 : alu_res;
            head_in  = (head_ff == LAST_P) ? '0 : head_ff + PTR_W'(1);
            count_in = count_ff - CNT_W'(1);
            state_in = S_READ;
         end
         S_ACQ_BUD: begin
            if ((budget_ff != '0) && !alu_carry) begin
               status_in = tbw_pkg::ST_DENY_BUDGET;
               state_in  = S_FLAG;
            end else begin
               state_in = S_ACQ_TOK;
            end
         end
         S_ACQ_TOK: begin
            if (alu_carry) begin
               status_in = tbw_pkg::ST_DENY_RATE;
            end else begin
               level_in = alu_res[LVL_W-1:0];
            end
            state_in = S_FLAG;
         end
         S_REC: begin
            if (ring_full) begin
               status_in = tbw_pkg::ST_WIN_FULL;
            end else begin
               sum_in   = alu_carry ? '1 : alu_res;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_FLAG;
         end
         S_FLAG: begin
            flag_in  = (budget_ff != '0) && !alu_carry;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= LVL_RST;
         tick_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         tick_ff  <= tick_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   // Payload and scratch
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      amount_ff <= amount_in;
      status_ff <= status_in;
      flag_ff   <= flag_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= tbw_pkg::RATE_RESET;
         burst_ff  <= tbw_pkg::BURST_RESET;
         budget_ff <= tbw_pkg::BUDGET_RESET;
         window_ff <= tbw_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         unique case (tbw_pkg::csr_index_type'(csr_index))
            tbw_pkg::CSR_RATE:   rate_ff   <= csr_wdata[tbw_pkg::RATE_W-1:0];
            tbw_pkg::CSR_BURST:  burst_ff  <= csr_wdata[tbw_pkg::TOKEN_W-1:0];
            tbw_pkg::CSR_BUDGET: budget_ff <= csr_wdata[tbw_pkg::USAGE_W-1:0];
            tbw_pkg::CSR_WINDOW: window_ff <= csr_wdata[tbw_pkg::WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Channel outputs
   assign req.ready            = (state_ff == S_IDLE);
   assign rsp.valid            = (state_ff == S_RESP);
   assign rsp.status           = status_ff;
   assign rsp.usage_total      = sum_ff;
   assign rsp.tokens_available = level_ff[LVL_W-1:F];
   assign rsp.budget_exceeded  = flag_ff;

endmodule

### src/tbw_checker.sv
// Port-level checks for the limiter, bound to the top level.
// Depends on tbw_pkg for status codes.
module tbw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tbw_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_budget_exceeded
);

   // One request in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // No accept while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while response pending");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response dropped or changed");

   // Budget denial implies the over-budget flag
   a_budget_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tbw_pkg::ST_DENY_BUDGET) |-> rsp_budget_exceeded)
      else $error("budget denial without budget flag");

   // Reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind token_bucket_with_window_budget tbw_checker u_tbw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req.valid),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_status          (rsp.status),
   .rsp_budget_exceeded (rsp.budget_exceeded)
);

### verif/tbw_tb_pkg.sv
// Scoreboard for the token bucket / window budget limiter testbench.
// Holds a cycle-free predictor of the limiter and the queue of awaited responses.
// Depends on tbw_pkg for field widths, codes and register reset values.
package tbw_tb_pkg;
   import tbw_pkg::*;

   localparam int RING_DEPTH = WINDOW_DEPTH_DEF;
   localparam int FRAC_BITS  = TOKEN_FRACTION_BITS_DEF;
   localparam logic [63:0] WHOLE_TOKEN = 64'd1 << FRAC_BITS;

   // One predicted response
   typedef struct {
      status_type          status;
      logic [USAGE_W-1:0]  usage_total;
      logic [TOKEN_W-1:0]  tokens;
      logic                budget_hit;
   } verdict_type;

   class limiter_scoreboard;
      // limit registers
      logic [RATE_W-1:0]    rate;
      logic [TOKEN_W-1:0]   burst;
      logic [USAGE_W-1:0]   budget;
      logic [WINDOW_W-1:0]  window;

      // limiter state
      logic [63:0]          token_level;
      logic [TICK_W-1:0]    current_tick;
      logic [TICK_W-1:0]    ring_stamp [RING_DEPTH];
      logic [AMOUNT_W-1:0]  ring_amount [RING_DEPTH];
      int unsigned          ring_head;
      int unsigned          ring_count;
      logic [USAGE_W-1:0]   usage_sum;

      verdict_type          pending_verdicts [$];
      int unsigned          failures;

      function new();
         rate         = RATE_RESET;
         burst        = BURST_RESET;
         budget       = BUDGET_RESET;
         window       = WINDOW_RESET;
         token_level  = bucket_cap();
         current_tick = '0;
         ring_head    = 0;
         ring_count   = 0;
         usage_sum    = '0;
         failures     = 0;
      endfunction

      function int unsigned pending();
         return pending_verdicts.size();
      endfunction

      // Zero burst counts as one token
      function logic [63:0] bucket_cap();
         logic [63:0] whole;
         whole = (burst == '0) ? 64'd1 : 64'(burst);
         return whole << FRAC_BITS;
      endfunction

      function bit over_budget();
         return budget != '0 && usage_sum >= budget;
      endfunction

      function void write_limit_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RATE:   rate   = data[RATE_W-1:0];
            CSR_BURST:  burst  = data[TOKEN_W-1:0];
            CSR_BUDGET: budget = data[USAGE_W-1:0];
            CSR_WINDOW: window = data[WINDOW_W-1:0];
            default: ;
         endcase
      endfunction

      // Refill, clip to cap, then retire records older than the window
      function void advance_tick();
         logic [63:0]       increment;
         logic [TICK_W-1:0] age;
         current_tick = current_tick + 1'b1;
         increment = (rate == '0) ? WHOLE_TOKEN : 64'(rate);
         token_level = token_level + increment;
         if (token_level > bucket_cap()) token_level = bucket_cap();
         while (ring_count > 0) begin
            age = current_tick - ring_stamp[ring_head];
            if (age <= window) break;
            if (usage_sum > USAGE_W'(ring_amount[ring_head]))
               usage_sum = usage_sum - USAGE_W'(ring_amount[ring_head]);
            else
               usage_sum = '0;
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_count--;
         end
      endfunction

      function status_type take_token();
         if (over_budget()) return ST_DENY_BUDGET;
         if (token_level >= WHOLE_TOKEN) begin
            token_level = token_level - WHOLE_TOKEN;
            return ST_OK;
         end
         return ST_DENY_RATE;
      endfunction

      // Append to the ring unless it is full; the running sum saturates
      function status_type append_record(logic [AMOUNT_W-1:0] amount);
         logic [USAGE_W:0] total;
         int unsigned      slot;
         if (ring_count >= RING_DEPTH) return ST_WIN_FULL;
         slot = (ring_head + ring_count) % RING_DEPTH;
         ring_stamp[slot]  = current_tick;
         ring_amount[slot] = amount;
         ring_count++;
         total = {1'b0, usage_sum} + (USAGE_W + 1)'(amount);
         usage_sum = total[USAGE_W] ? '1 : total[USAGE_W-1:0];
         return ST_OK;
      endfunction

      // Called for each accepted request: update state, queue the response
      function void note_request(logic [OP_W-1:0] op, logic [AMOUNT_W-1:0] amount);
         verdict_type v;
         v.status = ST_OK;
         case (op)
            OP_TICK:    advance_tick();
            OP_ACQUIRE: v.status = take_token();
            OP_RECORD:  v.status = append_record(amount);
            default: ;
         endcase
         v.usage_total = usage_sum;
         v.tokens      = TOKEN_W'(token_level >> FRAC_BITS);
         v.budget_hit  = over_budget();
         pending_verdicts.insert(pending_verdicts.size(), v);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [USAGE_W-1:0] usage,
                                   logic [TOKEN_W-1:0] tokens, logic hit);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response, expected none actual status %0d usage %0d",
                     $time, status, usage);
            failures++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare_field("status", 64'(want.status), 64'(status));
         compare_field("usage_total", 64'(want.usage_total), 64'(usage));
         compare_field("tokens_available", 64'(want.tokens), 64'(tokens));
         compare_field("budget_exceeded", 64'(want.budget_hit), 64'(hit));
      endfunction
   endclass

endpackage

### verif/tb_token_bucket_with_window_budget.sv
// Top-level testbench for token_bucket_with_window_budget: directed cases, then
// random request traffic over several limit settings and idle patterns.
// Depends on tbw_pkg, the channel interfaces and the scoreboard in tbw_tb_pkg.
module tb_token_bucket_with_window_budget;
   import tbw_pkg::*;
   import tbw_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int          SEGMENT_ITEMS = 250;
   localparam int          SETTLE_CYCLES = 300;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   int                      send_idle_pct;
   int                      recv_idle_pct;
   int unsigned             cycle_count;

   limiter_scoreboard board = new();

   tbw_req_if req_ch ();
   tbw_rsp_if rsp_ch ();

   token_bucket_with_window_budget dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Response side: random back-pressure, changes on the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Check each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_response(rsp_ch.status, rsp_ch.usage_total,
                              rsp_ch.tokens_available, rsp_ch.budget_exceeded);
   end

   // Timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Present one request and hold it until accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.usage_amount <= amount;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(op, amount);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_limit_reg(idx, data);
   endtask

   task automatic program_limits(input logic [RATE_W-1:0] rate, input logic [TOKEN_W-1:0] burst,
                                 input logic [USAGE_W-1:0] budget,
                                 input logic [WINDOW_W-1:0] window);
      write_reg(CSR_RATE, CSR_DATA_W'(rate));
      write_reg(CSR_BURST, CSR_DATA_W'(burst));
      write_reg(CSR_BUDGET, CSR_DATA_W'(budget));
      write_reg(CSR_WINDOW, CSR_DATA_W'(window));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Stop sending and wait until every response is back and the block is idle
   task automatic drain_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly small amounts, with extremes and full-range values mixed in
   function automatic logic [AMOUNT_W-1:0] pick_amount();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return $urandom_range(2000, 0);
      endcase
   endfunction

   // Random traffic in runs: acquire bursts drain the bucket, record runs fill
   // the ring, tick runs refill and expire; op 3 noise is not counted
   task automatic run_traffic(input int items);
      int sent;
      int run_len;
      int pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99, 0);
         if (pick < 30) begin
            run_len = $urandom_range(12, 1);
            repeat (run_len) send_request(OP_ACQUIRE, $urandom);
            sent += run_len;
         end else if (pick < 55) begin
            run_len = ($urandom_range(7, 0) == 0) ? $urandom_range(72, 60)
                                                  : $urandom_range(10, 1);
            repeat (run_len) send_request(OP_RECORD, pick_amount());
            sent += run_len;
         end else if (pick < 80) begin
            run_len = $urandom_range(6, 1);
            repeat (run_len) send_request(OP_TICK, $urandom);
            sent += run_len;
         end else if (pick < 95) begin
            send_request(OP_W'($urandom_range(2, 0)), pick_amount());
            sent++;
         end else begin
            send_request(OP_UNUSED, $urandom);
         end
      end
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.op           = '0;
      req_ch.usage_amount = '0;
      rsp_ch.ready        = 1'b0;
      send_idle_pct       = 19;
      recv_idle_pct       = 72;
      cycle_count         = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset limits, unused op, extreme amounts
      send_request(OP_UNUSED, '1);
      send_request(OP_ACQUIRE, '0);
      send_request(OP_RECORD, '0);
      send_request(OP_RECORD, '1);
      send_request(OP_TICK, '1);
      send_request(OP_ACQUIRE, '1);
      drain_requests();

      // Lowered cap, small budget, one-tick window
      program_limits(32'h0000_4000, 16'd1, 48'd5, 32'd1);
      send_request(OP_ACQUIRE, '0);   // over budget, level above the new cap
      send_request(OP_TICK, '0);      // clips level, expires both records
      send_request(OP_ACQUIRE, '0);
      send_request(OP_ACQUIRE, '0);   // bucket empty
      send_request(OP_RECORD, 32'd5); // reaches budget
      send_request(OP_ACQUIRE, '0);
      send_request(OP_TICK, '0);
      send_request(OP_TICK, '0);      // record ages out
      send_request(OP_ACQUIRE, '0);
      send_request(OP_UNUSED, '0);
      drain_requests();

      // Random segments: idle pattern changes every two segments
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg)
            0: program_limits('0, '0, '1, 32'd1);
            1: program_limits('1, '1, 48'd1, '1);
            2: program_limits(RATE_W'($urandom_range(32'h0002_0000, 1)),
                              TOKEN_W'($urandom_range(6, 1)),
                              USAGE_W'($urandom_range(20000, 1)),
                              WINDOW_W'($urandom_range(8, 1)));
            3: program_limits(32'h0000_8000, 16'd2, '0,
                              WINDOW_W'($urandom_range(100, 10)));
            4: program_limits($urandom, TOKEN_W'($urandom),
                              USAGE_W'($urandom) << $urandom_range(16, 0),
                              WINDOW_W'($urandom_range(50, 1)));
            default: program_limits(RATE_W'($urandom_range(32'h0001_0000, 0)),
                                    TOKEN_W'($urandom_range(4, 1)),
                                    USAGE_W'($urandom_range(32'hFFFF_FFFF, 1)),
                                    WINDOW_W'($urandom_range(4, 1)));
         endcase
         run_traffic(SEGMENT_ITEMS);
         drain_requests();
      end

      // Catch any stray late response
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
